[hw/rtl/qau_pkg.sv]
// Shared types, constants and rounding helpers for the quaternion arithmetic unit.
// Depends on nothing; every other file imports it.
package qau_pkg;

    localparam int WORD_W   = 32;
    localparam int FRAC_W   = 16;
    localparam int PROD_W   = 2 * WORD_W;
    localparam int ACC_W    = PROD_W + 4;
    localparam int N_W      = PROD_W + 1;
    localparam int ROOT_W   = WORD_W + 1;
    localparam int T_W      = N_W + 2;
    localparam int Q_W      = WORD_W;
    localparam int DIV_W    = N_W + Q_W + 1;
    localparam int KIND_W   = 3;
    localparam int S_DATA_W = 8 * WORD_W;
    localparam int M_DATA_W = 4 * WORD_W;
    localparam int M_USER_W = 2;

    typedef logic [KIND_W-1:0]        kind_t;
    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [ACC_W-1:0]  acc_t;

    localparam kind_t OP_MULT = 3'd0;
    localparam kind_t OP_ADD  = 3'd1;
    localparam kind_t OP_SUB  = 3'd2;
    localparam kind_t OP_NORM = 3'd3;
    localparam kind_t OP_INV  = 3'd4;
    localparam kind_t OP_ROT  = 3'd5;
    localparam kind_t OP_DOT  = 3'd6;

    localparam word_t WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam word_t WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};
    localparam logic [Q_W-1:0] TOP_MAG = Q_W'(1) << (WORD_W - 1);

    typedef struct packed {
        logic  sat;
        word_t w;
    } satw_t;

    typedef struct packed {
        kind_t            kind;
        word_t [3:0]      a;
        logic [N_W-1:0]   n;
        word_t [3:0]      res;
        logic             sat;
    } item_t;

    function automatic acc_t ext(input prod_t p);
        return acc_t'(p);
    endfunction

    function automatic satw_t sat_acc(input acc_t v);
        satw_t r;
        acc_t  hi_lim;
        acc_t  lo_lim;
        hi_lim = {{(ACC_W-WORD_W+1){1'b0}}, {(WORD_W-1){1'b1}}};
        lo_lim = {{(ACC_W-WORD_W+1){1'b1}}, {(WORD_W-1){1'b0}}};
        if (v > hi_lim) begin
            r.sat = 1'b1;
            r.w   = WORD_MAX;
        end else if (v < lo_lim) begin
            r.sat = 1'b1;
            r.w   = WORD_MIN;
        end else begin
            r.sat = 1'b0;
            r.w   = v[WORD_W-1:0];
        end
        return r;
    endfunction

    // Round half up from 2*FRAC_W to FRAC_W fraction bits, then saturate.
    function automatic satw_t rnd_sat(input acc_t v);
        acc_t t;
        t = v + (acc_t'(1) <<< (FRAC_W - 1));
        return sat_acc(t >>> FRAC_W);
    endfunction

endpackage

[hw/rtl/qau_front.sv]
// Multiplier pipeline: products, sums, rounding and the rotation matrix.
// Seven register stages; depends on qau_pkg.
module qau_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  qau_pkg::kind_t       in_kind,
    input  qau_pkg::word_t [3:0] in_a,
    input  qau_pkg::word_t [3:0] in_b,
    output logic                 out_valid,
    output qau_pkg::item_t       out_item
);
    import qau_pkg::*;

    localparam int STAGES = 7;

    logic [STAGES-1:0] vld_reg;
    kind_t             kind_reg [STAGES];
    word_t [3:0]       a_reg [STAGES];
    word_t [3:0]       b_reg [STAGES];

    prod_t          pab_reg [4][4];
    prod_t          paa_reg [4][4];
    word_t          as_res_reg [4];
    logic           as_sat_reg;
    acc_t           as_wide [4];
    satw_t          as_fix [4];

    acc_t           mul_sum_reg [4];
    acc_t           dot_sum_reg;
    acc_t           norm_sum;
    logic [N_W-1:0] n2_reg;
    acc_t           rot_sum_reg [3][3];
    word_t          as_res2_reg [4];
    logic           as_sat2_reg;

    word_t          early_res_reg [4];
    logic           pre_sat_reg;
    word_t          coef_reg [3][3];
    logic [N_W-1:0] n3_reg;
    satw_t          mul_fix [4];
    satw_t          dot_fix;
    satw_t          coef_fix [3][3];
    word_t          early_next [4];
    logic           early_sat;
    logic           coef_sat;

    prod_t          rp_reg [3][3];
    word_t          early4_reg [4];
    logic           pre_sat4_reg;
    logic [N_W-1:0] n4_reg;

    acc_t           rs_reg [3];
    word_t          early5_reg [4];
    logic           pre_sat5_reg;
    logic [N_W-1:0] n5_reg;

    satw_t          rot_fix [3];
    item_t          out_item_reg;
    item_t          out_item_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            kind_reg[0] <= in_kind;
            a_reg[0]    <= in_a;
            b_reg[0]    <= in_b;
            for (int k = 1; k < STAGES; k++) begin
                kind_reg[k] <= kind_reg[k-1];
                a_reg[k]    <= a_reg[k-1];
                b_reg[k]    <= b_reg[k-1];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            if (kind_reg[0] == OP_SUB) begin
                as_wide[i] = acc_t'($signed(a_reg[0][i])) - acc_t'($signed(b_reg[0][i]));
            end else begin
                as_wide[i] = acc_t'($signed(a_reg[0][i])) + acc_t'($signed(b_reg[0][i]));
            end
            as_fix[i] = sat_acc(as_wide[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                for (int j = 0; j < 4; j++) begin
                    pab_reg[i][j] <= $signed(a_reg[0][i]) * $signed(b_reg[0][j]);
                    paa_reg[i][j] <= $signed(a_reg[0][i]) * $signed(a_reg[0][j]);
                end
                as_res_reg[i] <= as_fix[i].w;
            end
            as_sat_reg <= as_fix[0].sat | as_fix[1].sat | as_fix[2].sat | as_fix[3].sat;
        end
    end

    assign norm_sum = ext(paa_reg[0][0]) + ext(paa_reg[1][1])
                    + ext(paa_reg[2][2]) + ext(paa_reg[3][3]);

    always_ff @(posedge aclk) begin
        if (en) begin
            mul_sum_reg[0] <= ext(pab_reg[0][0]) - ext(pab_reg[1][1])
                            - ext(pab_reg[2][2]) - ext(pab_reg[3][3]);
            mul_sum_reg[1] <= ext(pab_reg[0][1]) + ext(pab_reg[1][0])
                            + ext(pab_reg[2][3]) - ext(pab_reg[3][2]);
            mul_sum_reg[2] <= ext(pab_reg[0][2]) - ext(pab_reg[1][3])
                            + ext(pab_reg[2][0]) + ext(pab_reg[3][1]);
            mul_sum_reg[3] <= ext(pab_reg[0][3]) + ext(pab_reg[1][2])
                            - ext(pab_reg[2][1]) + ext(pab_reg[3][0]);
            dot_sum_reg    <= ext(pab_reg[0][0]) + ext(pab_reg[1][1])
                            + ext(pab_reg[2][2]) + ext(pab_reg[3][3]);
            n2_reg         <= norm_sum[N_W-1:0];
            rot_sum_reg[0][0] <= ext(paa_reg[0][0]) + ext(paa_reg[1][1])
                               - ext(paa_reg[2][2]) - ext(paa_reg[3][3]);
            rot_sum_reg[1][1] <= ext(paa_reg[0][0]) - ext(paa_reg[1][1])
                               + ext(paa_reg[2][2]) - ext(paa_reg[3][3]);
            rot_sum_reg[2][2] <= ext(paa_reg[0][0]) - ext(paa_reg[1][1])
                               - ext(paa_reg[2][2]) + ext(paa_reg[3][3]);
            rot_sum_reg[0][1] <= (ext(paa_reg[1][2]) - ext(paa_reg[0][3])) <<< 1;
            rot_sum_reg[0][2] <= (ext(paa_reg[1][3]) + ext(paa_reg[0][2])) <<< 1;
            rot_sum_reg[1][0] <= (ext(paa_reg[1][2]) + ext(paa_reg[0][3])) <<< 1;
            rot_sum_reg[1][2] <= (ext(paa_reg[2][3]) - ext(paa_reg[0][1])) <<< 1;
            rot_sum_reg[2][0] <= (ext(paa_reg[1][3]) - ext(paa_reg[0][2])) <<< 1;
            rot_sum_reg[2][1] <= (ext(paa_reg[2][3]) + ext(paa_reg[0][1])) <<< 1;
            as_res2_reg <= as_res_reg;
            as_sat2_reg <= as_sat_reg;
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            mul_fix[i] = rnd_sat(mul_sum_reg[i]);
        end
        dot_fix  = rnd_sat(dot_sum_reg);
        coef_sat = 1'b0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                coef_fix[i][j] = rnd_sat(rot_sum_reg[i][j]);
                coef_sat       = coef_sat | coef_fix[i][j].sat;
            end
        end
        for (int i = 0; i < 4; i++) begin
            early_next[i] = '0;
        end
        early_sat = 1'b0;
        case (kind_reg[2])
            OP_MULT: begin
                for (int i = 0; i < 4; i++) begin
                    early_next[i] = mul_fix[i].w;
                    early_sat     = early_sat | mul_fix[i].sat;
                end
            end
            OP_ADD, OP_SUB: begin
                early_next = as_res2_reg;
                early_sat  = as_sat2_reg;
            end
            OP_DOT: begin
                early_next[0] = dot_fix.w;
                early_sat     = dot_fix.sat;
            end
            OP_ROT: begin
                early_sat = coef_sat;
            end
            default: begin
                early_sat = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            early_res_reg <= early_next;
            pre_sat_reg   <= early_sat;
            n3_reg        <= n2_reg;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    coef_reg[i][j] <= coef_fix[i][j].w;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    rp_reg[i][j] <= coef_reg[i][j] * $signed(b_reg[3][j+1]);
                end
            end
            early4_reg   <= early_res_reg;
            pre_sat4_reg <= pre_sat_reg;
            n4_reg       <= n3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                rs_reg[i] <= ext(rp_reg[i][0]) + ext(rp_reg[i][1]) + ext(rp_reg[i][2]);
            end
            early5_reg   <= early4_reg;
            pre_sat5_reg <= pre_sat4_reg;
            n5_reg       <= n4_reg;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            rot_fix[i] = rnd_sat(rs_reg[i]);
        end
        out_item_next.kind = kind_reg[5];
        out_item_next.a    = a_reg[5];
        out_item_next.n    = n5_reg;
        if (kind_reg[5] == OP_ROT) begin
            out_item_next.res[0] = '0;
            for (int i = 0; i < 3; i++) begin
                out_item_next.res[i+1] = rot_fix[i].w;
            end
            out_item_next.sat = pre_sat5_reg | rot_fix[0].sat | rot_fix[1].sat
                              | rot_fix[2].sat;
        end else begin
            for (int i = 0; i < 4; i++) begin
                out_item_next.res[i] = early5_reg[i];
            end
            out_item_next.sat = pre_sat5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_item_reg <= out_item_next;
        end
    end

    assign out_valid = vld_reg[STAGES-1];
    assign out_item  = out_item_reg;

endmodule

[hw/rtl/qau_sqrt.sv]
// Pipelined integer square root of the squared norm, one result bit per stage.
// Depends on qau_pkg.
module qau_sqrt (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  qau_pkg::item_t              in_item,
    output logic                        out_valid,
    output qau_pkg::item_t              out_item,
    output logic [qau_pkg::ROOT_W-1:0]  out_root
);
    import qau_pkg::*;

    logic              vld_reg  [ROOT_W];
    item_t             item_reg [ROOT_W];
    logic [N_W-1:0]    rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_step
        localparam int B = ROOT_W - 1 - k;

        logic              vld_in;
        item_t             item_in;
        logic [N_W-1:0]    rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [T_W-1:0]    trial;
        logic              take;

        if (k == 0) begin : g_first
            assign vld_in  = in_valid;
            assign item_in = in_item;
            assign rem_in  = in_item.n;
            assign root_in = '0;
        end else begin : g_next
            assign vld_in  = vld_reg[k-1];
            assign item_in = item_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
        end

        assign trial = (T_W'(root_in) << (B + 1)) + (T_W'(1) << (2 * B));
        assign take  = T_W'(rem_in) >= trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                item_reg[k] <= item_in;
                if (take) begin
                    rem_reg[k]  <= rem_in - trial[N_W-1:0];
                    root_reg[k] <= root_in | (ROOT_W'(1) << B);
                end else begin
                    rem_reg[k]  <= rem_in;
                    root_reg[k] <= root_in;
                end
            end
        end
    end

    assign out_valid = vld_reg[ROOT_W-1];
    assign out_item  = item_reg[ROOT_W-1];
    assign out_root  = root_reg[ROOT_W-1];

endmodule

[hw/rtl/qau_div.sv]
// Four-lane pipelined restoring divider for normalize and inverse, one quotient
// bit per stage, with final sign, saturation and zero-norm handling. Uses qau_pkg.
module qau_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  qau_pkg::item_t              in_item,
    input  logic [qau_pkg::ROOT_W-1:0]  in_root,
    output logic                        out_valid,
    output qau_pkg::item_t              out_item,
    output logic                        out_zero_norm
);
    import qau_pkg::*;

    localparam int DEPTH = Q_W + 1;

    logic             vld_reg  [DEPTH];
    item_t            item_reg [DEPTH];
    logic [N_W-1:0]   den_reg  [DEPTH];
    logic [3:0]       neg_reg  [DEPTH];
    logic [3:0]       ovf_reg  [DEPTH];
    logic [DIV_W-1:0] rem_reg  [DEPTH][4];
    logic [Q_W-1:0]   q_reg    [DEPTH][4];

    logic [N_W-1:0]    den;
    logic [WORD_W-1:0] mag [4];
    logic [DIV_W-1:0]  num [4];
    logic [3:0]        neg;
    logic [3:0]        ovf;

    always_comb begin
        den = (in_item.kind == OP_INV) ? in_item.n : N_W'(in_root);
        for (int l = 0; l < 4; l++) begin
            mag[l] = in_item.a[l][WORD_W-1] ? (~in_item.a[l] + 1'b1) : in_item.a[l];
            if (in_item.kind == OP_INV) begin
                num[l] = (DIV_W'(mag[l]) << (2 * FRAC_W)) + DIV_W'(den >> 1);
            end else begin
                num[l] = (DIV_W'(mag[l]) << FRAC_W) + DIV_W'(den >> 1);
            end
            ovf[l] = num[l] >= (DIV_W'(den) << Q_W);
            if (in_item.kind == OP_INV && l != 0) begin
                neg[l] = !in_item.a[l][WORD_W-1] && (in_item.a[l] != '0);
            end else begin
                neg[l] = in_item.a[l][WORD_W-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            item_reg[0] <= in_item;
            den_reg[0]  <= den;
            neg_reg[0]  <= neg;
            ovf_reg[0]  <= ovf;
            for (int l = 0; l < 4; l++) begin
                rem_reg[0][l] <= num[l];
                q_reg[0][l]   <= '0;
            end
        end
    end

    for (genvar k = 1; k < DEPTH; k++) begin : g_step
        localparam int B = Q_W - k;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                item_reg[k] <= item_reg[k-1];
                den_reg[k]  <= den_reg[k-1];
                neg_reg[k]  <= neg_reg[k-1];
                ovf_reg[k]  <= ovf_reg[k-1];
            end
        end

        for (genvar l = 0; l < 4; l++) begin : g_lane
            logic [DIV_W-1:0] sub;
            logic             ge;

            assign sub = DIV_W'(den_reg[k-1]) << B;
            assign ge  = rem_reg[k-1][l] >= sub;

            always_ff @(posedge aclk) begin
                if (en) begin
                    if (ge) begin
                        rem_reg[k][l] <= rem_reg[k-1][l] - sub;
                        q_reg[k][l]   <= q_reg[k-1][l] | (Q_W'(1) << B);
                    end else begin
                        rem_reg[k][l] <= rem_reg[k-1][l];
                        q_reg[k][l]   <= q_reg[k-1][l];
                    end
                end
            end
        end
    end

    item_t          last;
    logic [Q_W-1:0] q;
    word_t          quo [4];
    logic [3:0]     lane_sat;
    logic           divides;

    always_comb begin
        last    = item_reg[DEPTH-1];
        divides = (last.kind == OP_NORM) || (last.kind == OP_INV);
        for (int l = 0; l < 4; l++) begin
            q = q_reg[DEPTH-1][l];
            if (neg_reg[DEPTH-1][l]) begin
                if (ovf_reg[DEPTH-1][l] || q > TOP_MAG) begin
                    quo[l]      = WORD_MIN;
                    lane_sat[l] = 1'b1;
                end else begin
                    quo[l]      = ~q + 1'b1;
                    lane_sat[l] = 1'b0;
                end
            end else begin
                if (ovf_reg[DEPTH-1][l] || q[Q_W-1]) begin
                    quo[l]      = WORD_MAX;
                    lane_sat[l] = 1'b1;
                end else begin
                    quo[l]      = q;
                    lane_sat[l] = 1'b0;
                end
            end
        end
        out_item      = last;
        out_zero_norm = 1'b0;
        if (divides) begin
            if (last.n == '0) begin
                out_item.res  = '0;
                out_item.sat  = 1'b0;
                out_zero_norm = 1'b1;
            end else begin
                for (int l = 0; l < 4; l++) begin
                    out_item.res[l] = quo[l];
                end
                out_item.sat = |lane_sat;
            end
        end
    end

    assign out_valid = vld_reg[DEPTH-1];

endmodule

[hw/rtl/quaternion_arithmetic_unit.sv]
// Top level of the quaternion arithmetic unit: stream ports, pipeline stall
// control and output register. Uses qau_pkg, qau_front, qau_sqrt and qau_div.
//
//   Channel   Ports                     Contents
//   request   s_tvalid/s_tready         s_tdata, s_tuser
//   result    m_tvalid/m_tready         m_tdata, m_tuser
//
// A new request is taken every cycle unless a result waits unread. Each result
// goes through the front, the one-bit-per-stage square root and divider pipes.
// Reset clears every valid bit; data registers are not reset.
// When a result waits unread the whole pipeline holds and s_tready is low.
module quaternion_arithmetic_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [qau_pkg::S_DATA_W-1:0]     s_tdata,  // a_s, a_x, a_y, a_z, b_s, b_x, b_y, b_z
    input  logic [qau_pkg::KIND_W-1:0]       s_tuser,  // kind
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [qau_pkg::M_DATA_W-1:0]     m_tdata,  // r_s, r_x, r_y, r_z
    output logic [qau_pkg::M_USER_W-1:0]     m_tuser   // zero_norm, saturated
);
    import qau_pkg::*;

    logic                en;
    word_t [3:0]         in_a;
    word_t [3:0]         in_b;
    logic                front_valid;
    item_t               front_item;
    logic                sqrt_valid;
    item_t               sqrt_item;
    logic [ROOT_W-1:0]   sqrt_root;
    logic                div_valid;
    item_t               div_item;
    logic                div_zero_norm;

    logic                m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;
    logic [M_USER_W-1:0] m_tuser_reg;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            in_a[i] = s_tdata[WORD_W*i +: WORD_W];
            in_b[i] = s_tdata[WORD_W*(i+4) +: WORD_W];
        end
    end

    qau_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_kind   (s_tuser),
        .in_a      (in_a),
        .in_b      (in_b),
        .out_valid (front_valid),
        .out_item  (front_item)
    );

    qau_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (front_valid),
        .in_item   (front_item),
        .out_valid (sqrt_valid),
        .out_item  (sqrt_item),
        .out_root  (sqrt_root)
    );

    qau_div u_div (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .en            (en),
        .in_valid      (sqrt_valid),
        .in_item       (sqrt_item),
        .in_root       (sqrt_root),
        .out_valid     (div_valid),
        .out_item      (div_item),
        .out_zero_norm (div_zero_norm)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= div_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= div_item.res;
            m_tuser_reg <= {div_item.sat, div_zero_norm};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_zero_norm_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("zero norm result carries nonzero data");

    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("zero norm and saturation raised together");

    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("request taken while the result is stalled");

    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

[verif/qau_checker.sv]
// Result checker for the quaternion arithmetic unit: watches both stream channels,
// works out each expected result in signed fixed point and compares field by field.
// Depends on qau_pkg for widths and operation codes.
module qau_checker (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    input  logic                         s_tready,
    input  logic [qau_pkg::S_DATA_W-1:0] s_tdata,
    input  logic [qau_pkg::KIND_W-1:0]   s_tuser,
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic [qau_pkg::M_DATA_W-1:0] m_tdata,
    input  logic [qau_pkg::M_USER_W-1:0] m_tuser,
    output int                           fail_count,
    output int                           pending
);
    import qau_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [135:0] big_t;

    typedef struct packed {
        logic        sat;
        logic        zn;
        word_t [3:0] r;
    } quat_result_t;

    quat_result_t result_fifo[$];

    function automatic big_t mul(input word_t x, input word_t y);
        return big_t'(x) * big_t'(y);
    endfunction

    function automatic word_t clamp(input big_t v, inout logic sat);
        if (v > big_t'(WORD_MAX)) begin
            sat = 1'b1;
            return WORD_MAX;
        end
        if (v < big_t'(WORD_MIN)) begin
            sat = 1'b1;
            return WORD_MIN;
        end
        return word_t'(v);
    endfunction

    function automatic word_t round_clamp(input big_t v, inout logic sat);
        big_t t;
        t = v + (big_t'(1) <<< (FRAC_W - 1));
        return clamp(t >>> FRAC_W, sat);
    endfunction

    function automatic word_t div_clamp(input logic neg, input big_t mag, input big_t den,
                                        inout logic sat);
        big_t q;
        q = (mag + (den >>> 1)) / den;
        if (neg) q = -q;
        return clamp(q, sat);
    endfunction

    function automatic big_t isqrt(input big_t n);
        big_t root;
        big_t cand;
        root = '0;
        for (int b = 63; b >= 0; b--) begin
            cand = root | (big_t'(1) << b);
            if (cand * cand <= n) root = cand;
        end
        return root;
    endfunction

    function automatic quat_result_t quat_eval(input kind_t kind, input word_t [3:0] a,
                                               input word_t [3:0] b);
        quat_result_t res;
        logic         sat;
        big_t         n;
        big_t         acc;
        big_t         mag;
        word_t        m[3][3];
        sat = 1'b0;
        res = '0;
        case (kind)
            OP_MULT: begin
                res.r[0] = round_clamp(mul(a[0], b[0]) - mul(a[1], b[1]) - mul(a[2], b[2])
                                       - mul(a[3], b[3]), sat);
                res.r[1] = round_clamp(mul(a[0], b[1]) + mul(a[1], b[0]) + mul(a[2], b[3])
                                       - mul(a[3], b[2]), sat);
                res.r[2] = round_clamp(mul(a[0], b[2]) - mul(a[1], b[3]) + mul(a[2], b[0])
                                       + mul(a[3], b[1]), sat);
                res.r[3] = round_clamp(mul(a[0], b[3]) + mul(a[1], b[2]) - mul(a[2], b[1])
                                       + mul(a[3], b[0]), sat);
            end
            OP_ADD, OP_SUB: begin
                for (int i = 0; i < 4; i++)
                    res.r[i] = clamp(kind == OP_ADD ? big_t'(a[i]) + big_t'(b[i])
                                                    : big_t'(a[i]) - big_t'(b[i]), sat);
            end
            OP_NORM, OP_INV: begin
                n = '0;
                for (int i = 0; i < 4; i++) n = n + mul(a[i], a[i]);
                if (n == 0) begin
                    res.zn = 1'b1;
                end else begin
                    for (int i = 0; i < 4; i++) begin
                        mag = a[i] < 0 ? -big_t'(a[i]) : big_t'(a[i]);
                        if (kind == OP_NORM)
                            res.r[i] = div_clamp(a[i] < 0, mag <<< FRAC_W, isqrt(n), sat);
                        else
                            res.r[i] = div_clamp(i == 0 ? a[i] < 0 : a[i] > 0,
                                                 mag <<< (2 * FRAC_W), n, sat);
                    end
                end
            end
            OP_ROT: begin
                m[0][0] = round_clamp(mul(a[0], a[0]) + mul(a[1], a[1]) - mul(a[2], a[2])
                                      - mul(a[3], a[3]), sat);
                m[1][1] = round_clamp(mul(a[0], a[0]) - mul(a[1], a[1]) + mul(a[2], a[2])
                                      - mul(a[3], a[3]), sat);
                m[2][2] = round_clamp(mul(a[0], a[0]) - mul(a[1], a[1]) - mul(a[2], a[2])
                                      + mul(a[3], a[3]), sat);
                m[0][1] = round_clamp(2 * (mul(a[1], a[2]) - mul(a[0], a[3])), sat);
                m[0][2] = round_clamp(2 * (mul(a[1], a[3]) + mul(a[0], a[2])), sat);
                m[1][0] = round_clamp(2 * (mul(a[1], a[2]) + mul(a[0], a[3])), sat);
                m[1][2] = round_clamp(2 * (mul(a[2], a[3]) - mul(a[0], a[1])), sat);
                m[2][0] = round_clamp(2 * (mul(a[1], a[3]) - mul(a[0], a[2])), sat);
                m[2][1] = round_clamp(2 * (mul(a[2], a[3]) + mul(a[0], a[1])), sat);
                for (int i = 0; i < 3; i++) begin
                    acc = '0;
                    for (int j = 0; j < 3; j++) acc = acc + mul(m[i][j], b[1 + j]);
                    res.r[1 + i] = round_clamp(acc, sat);
                end
            end
            OP_DOT: begin
                res.r[0] = round_clamp(mul(a[0], b[0]) + mul(a[1], b[1]) + mul(a[2], b[2])
                                       + mul(a[3], b[3]), sat);
            end
            default: ;
        endcase
        res.sat = sat;
        return res;
    endfunction

    task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch in %s: got %h, expected %h", field, got, want);
        fail_count++;
    endtask

    initial begin
        fail_count = 0;
        pending = 0;
    end

    always @(posedge aclk) begin
        quat_result_t want;
        word_t [3:0]  qa;
        word_t [3:0]  qb;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                for (int i = 0; i < 4; i++) begin
                    qa[i] = s_tdata[WORD_W*i +: WORD_W];
                    qb[i] = s_tdata[WORD_W*(i + 4) +: WORD_W];
                end
                result_fifo.push_back(quat_eval(kind_t'(s_tuser), qa, qb));
            end
            if (m_tvalid && m_tready) begin
                if (result_fifo.size() == 0) begin
                    report("unexpected result", m_tdata[31:0], '0);
                end else begin
                    want = result_fifo.pop_front();
                    for (int i = 0; i < 4; i++)
                        if (m_tdata[WORD_W*i +: WORD_W] !== want.r[i])
                            report($sformatf("component %0d", i),
                                   m_tdata[WORD_W*i +: WORD_W], want.r[i]);
                    if (m_tuser[0] !== want.zn) report("zero_norm", m_tuser[0], want.zn);
                    if (m_tuser[1] !== want.sat) report("saturated", m_tuser[1], want.sat);
                end
            end
            pending <= result_fifo.size();
        end
    end
endmodule

[verif/tb.sv]
// Testbench top for the quaternion arithmetic unit: clock, reset, request stimulus
// with random gaps, result back-pressure, watchdog and verdict.
// Depends on qau_pkg, quaternion_arithmetic_unit and qau_checker.
module tb;
    import qau_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam kind_t OP_NONE = 3'd7;
    localparam int    IDLE_LIMIT = 20000;
    localparam int    RANDOM_REQUESTS = 1250;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic [KIND_W-1:0]   s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic [M_USER_W-1:0] m_tuser;
    logic                s_fire;
    logic                m_fire;
    logic                no_gaps;
    int                  fail_count;
    int                  pending;
    int                  idle_cycles;

    quaternion_arithmetic_unit dut (.*);

    qau_checker u_checker (.*);

    always begin
        aclk = 1'b1;
        #1;
        aclk = 1'b0;
        #1;
    end

    always_ff @(posedge aclk) begin
        s_fire <= s_tvalid & s_tready;
        m_fire <= m_tvalid & m_tready;
        if (!aresetn || s_fire || m_fire) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    always begin
        int stall;
        @(negedge aclk);
        stall = aresetn ? gap_len() : 0;
        m_tready = (stall == 0);
        repeat (stall) @(negedge aclk);
        m_tready = 1'b1;
    end

    task automatic send(input kind_t kind, input word_t [7:0] q);
        int gap;
        s_tuser  = kind;
        s_tdata  = q;
        s_tvalid = 1'b1;
        @(negedge aclk);
        while (!s_fire) @(negedge aclk);
        gap = gap_len();
        if (gap != 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    function automatic word_t rand_word(input int mode);
        case (mode)
            0: return word_t'($urandom());
            1: return word_t'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
            2: return word_t'($signed($urandom_range(0, 32'h0000_4000)) - 32'sh0000_2000);
            default: return $urandom_range(0, 1) ? WORD_MAX : WORD_MIN;
        endcase
    endfunction

    initial begin
        word_t [7:0] q;
        kind_t       kind;
        int          mode;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        m_tready = 1'b0;
        no_gaps  = 1'b0;
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;

        for (int k = 0; k < 8; k++) begin
            send(kind_t'(k), {8{WORD_MAX}});
            send(kind_t'(k), {8{WORD_MIN}});
            q = '0;
            q[0] = 32'sh0001_0000;
            q[5] = 32'sh0002_8000;
            q[7] = -32'sh0000_4000;
            send(kind_t'(k), q);
        end
        send(OP_NORM, '0);
        send(OP_INV, '0);

        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n % 200 == 0) no_gaps = ($urandom_range(0, 2) == 0);
            mode = $urandom_range(0, 9);
            mode = mode < 3 ? 0 : mode < 6 ? 1 : mode < 9 ? 2 : 3;
            for (int i = 0; i < 8; i++) q[i] = rand_word($urandom_range(0, 4) == 0 ? 0 : mode);
            if ($urandom_range(0, 19) == 0) q[3:0] = '0;
            kind = $urandom_range(0, 15) == 0 ? OP_NONE : kind_t'($urandom_range(0, 6));
            send(kind, q);
        end
        s_tvalid = 1'b0;

        while (pending != 0 || s_fire) @(negedge aclk);
        repeat (100) @(negedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
